// ===== rtl/core/latency_window_percentile_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LATENCY_WINDOW_PERCENTILE_TOP_DEFINES_SVH
`define LATENCY_WINDOW_PERCENTILE_TOP_DEFINES_SVH

// Implication checked in the same cycle, suspended while reset is high.
`define LWP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Implication checked in the next cycle, suspended while reset is high.
`define LWP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Implication checked in the next cycle, active during reset too.
`define LWP_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/lwp_pkg.sv =====
package lwp_pkg;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;

  localparam int STAGE_W   = 3;
  localparam int LAT_W     = 32;
  localparam int SAMPLE_W  = 31;
  localparam int COUNT_W   = 9;
  localparam int CFG_W     = 9;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 9'd256;

  localparam int PCT_50 = 50;
  localparam int PCT_95 = 95;
  localparam int PCT_99 = 99;
  localparam int ROUND_HALF = 50;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2**20.
  localparam int RECIP_W = 20;
  localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;
  localparam int RECIP_SHIFT = 26;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CAND,
    S_FETCH,
    S_SCAN,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/lwp_req_if.sv =====
interface lwp_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [lwp_pkg::STAGE_W-1:0]       stage;
  logic signed [lwp_pkg::LAT_W-1:0]  latency;

  modport source (output valid, cmd, stage, latency, input ready);
  modport sink (input valid, cmd, stage, latency, output ready);
endinterface

// ===== rtl/core/lwp_rsp_if.sv =====
interface lwp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [lwp_pkg::COUNT_W-1:0]    sample_count;
  logic [lwp_pkg::SAMPLE_W-1:0]   p50_value;
  logic [lwp_pkg::SAMPLE_W-1:0]   p95_value;
  logic [lwp_pkg::SAMPLE_W-1:0]   p99_value;

  modport source (output valid, accepted, sample_count, p50_value, p95_value, p99_value,
                  input ready);
  modport sink (input valid, accepted, sample_count, p50_value, p95_value, p99_value,
                output ready);
endinterface

// ===== rtl/core/lwp_ram.sv =====
module lwp_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/latency_window_percentile_top.sv =====
// Channel  Role    Payload
// req      sink    cmd, stage, latency
// rsp      source  accepted, sample_count, p50_value, p95_value, p99_value
// cfg      write   cfg_wdata (window_size), strobed by cfg_we
//
// An observe transaction is a read-modify-write of the stage's count and ring
// pointer plus one write to the sample RAM.
// A report over n samples makes every sample a candidate, and the single RAM
// read port scans the whole window for each.
// Reset clears the counts and pointers at once; the sample RAM is not cleared.
// A waiting result holds the output register; a new request is taken when the
// block is idle and that register is empty or drains in the same cycle.
module latency_window_percentile_top #(
  parameter int NUM_STAGES = 8,
  parameter int WINDOW_MAX = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lwp_pkg::CFG_W-1:0]  cfg_wdata,
  lwp_req_if.sink                    req,
  lwp_rsp_if.source                  rsp
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int PW = $clog2(WINDOW_MAX);
  localparam int AW = $clog2(NUM_STAGES * WINDOW_MAX);
  localparam int SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int XW = $clog2(lwp_pkg::PCT_99 * WINDOW_MAX + lwp_pkg::ROUND_HALF + 1);
  localparam int MW = XW + lwp_pkg::RECIP_W;

  function automatic logic [PW-1:0] ring(input logic [PW:0] s);
    logic [PW:0] r;
    r = (32'(s) >= WINDOW_MAX) ? s - (PW+1)'(WINDOW_MAX) : s;
    return r[PW-1:0];
  endfunction

  function automatic logic [CW-1:0] div100(input logic [XW-1:0] x);
    logic [MW-1:0] p;
    p = MW'(x) * MW'(lwp_pkg::RECIP_100);
    return CW'(p >> lwp_pkg::RECIP_SHIFT);
  endfunction

  logic [lwp_pkg::CFG_W-1:0] window_size;
  logic [CW-1:0] eff_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= lwp_pkg::WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (window_size == '0) begin
      eff_window = CW'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      eff_window = CW'(WINDOW_MAX);
    end else begin
      eff_window = CW'(window_size);
    end
  end

  logic [CW-1:0] win_count [NUM_STAGES];
  logic [PW-1:0] oldest [NUM_STAGES];

  lwp_pkg::state_t state, state_next;

  logic accept;
  logic stage_ok;
  logic [SW-1:0] sidx;
  logic [AW-1:0] sbase;

  // Observe path.
  logic [CW-1:0] n_cur, drop, n_keep;
  logic          full;
  logic [PW-1:0] ptr_new, wr_slot;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [lwp_pkg::SAMPLE_W-1:0] ram_rdata;

  // Report path.
  logic [AW-1:0] rbase;
  logic [PW-1:0] rptr;
  logic [CW-1:0] rn, ci, cj, lt_cnt, le_cnt, ridx;
  logic [CW-1:0] k50, k95, k99;
  logic [XW-1:0] x50, x95, x99;
  logic [lwp_pkg::SAMPLE_W-1:0] cand, r50, r95, r99;

  logic rsp_valid;

  assign stage_ok = 32'(req.stage) < NUM_STAGES;
  assign sidx     = SW'(req.stage);
  assign sbase    = AW'(32'(req.stage) * WINDOW_MAX);
  assign accept   = req.valid && req.ready;

  assign n_cur   = win_count[sidx];
  assign full    = n_cur >= eff_window;
  assign drop    = ((n_cur >> 2) == '0) ? CW'(1) : (n_cur >> 2);
  assign n_keep  = full ? n_cur - drop : n_cur;
  assign ptr_new = full ? ring({1'b0, oldest[sidx]} + (PW+1)'(drop)) : oldest[sidx];
  assign wr_slot = ring({1'b0, ptr_new} + (PW+1)'(n_keep));

  assign ram_we    = accept && stage_ok && (req.cmd == lwp_pkg::CMD_OBSERVE) &&
                     !req.latency[lwp_pkg::LAT_W-1];
  assign ram_waddr = sbase + AW'(wr_slot);

  always_comb begin
    case (state)
      lwp_pkg::S_CAND:  ridx = ci;
      lwp_pkg::S_FETCH: ridx = '0;
      default:          ridx = cj;
    endcase
  end
  assign ram_raddr = rbase + AW'(ring({1'b0, rptr} + (PW+1)'(ridx)));

  lwp_ram #(
    .WIDTH(lwp_pkg::SAMPLE_W),
    .DEPTH(NUM_STAGES * WINDOW_MAX)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.latency[lwp_pkg::SAMPLE_W-1:0]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req.ready = (state == lwp_pkg::S_IDLE) && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lwp_pkg::S_IDLE: begin
        if (accept && stage_ok && (req.cmd == lwp_pkg::CMD_REPORT) && (n_cur != '0)) begin
          state_next = lwp_pkg::S_MUL;
        end
      end
      lwp_pkg::S_MUL:   state_next = lwp_pkg::S_DIV;
      lwp_pkg::S_DIV:   state_next = lwp_pkg::S_CAND;
      lwp_pkg::S_CAND:  state_next = lwp_pkg::S_FETCH;
      lwp_pkg::S_FETCH: state_next = lwp_pkg::S_SCAN;
      lwp_pkg::S_SCAN: begin
        if (cj == rn) begin
          state_next = lwp_pkg::S_EVAL;
        end
      end
      lwp_pkg::S_EVAL: begin
        state_next = (ci + CW'(1) == rn) ? lwp_pkg::S_DONE : lwp_pkg::S_CAND;
      end
      lwp_pkg::S_DONE:  state_next = lwp_pkg::S_IDLE;
      default:          state_next = lwp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        win_count[s] <= '0;
        oldest[s]    <= '0;
      end
    end else if (ram_we) begin
      win_count[sidx] <= n_keep + CW'(1);
      oldest[sidx]    <= ptr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((accept && !(stage_ok && (req.cmd == lwp_pkg::CMD_REPORT) && (n_cur != '0)))
                 || (state == lwp_pkg::S_DONE)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lwp_pkg::S_IDLE: begin
        if (accept) begin
          rbase <= sbase;
          rptr  <= oldest[sidx];
          rn    <= n_cur;
          rsp.accepted     <= ram_we;
          rsp.p50_value    <= '0;
          rsp.p95_value    <= '0;
          rsp.p99_value    <= '0;
          if (!stage_ok) begin
            rsp.sample_count <= '0;
          end else if (ram_we) begin
            rsp.sample_count <= lwp_pkg::COUNT_W'(n_keep + CW'(1));
          end else begin
            rsp.sample_count <= lwp_pkg::COUNT_W'(n_cur);
          end
        end
        ci <= '0;
      end
      lwp_pkg::S_MUL: begin
        x50 <= XW'(lwp_pkg::PCT_50 * (32'(rn) - 1) + lwp_pkg::ROUND_HALF);
        x95 <= XW'(lwp_pkg::PCT_95 * (32'(rn) - 1) + lwp_pkg::ROUND_HALF);
        x99 <= XW'(lwp_pkg::PCT_99 * (32'(rn) - 1) + lwp_pkg::ROUND_HALF);
      end
      lwp_pkg::S_DIV: begin
        k50 <= div100(x50);
        k95 <= div100(x95);
        k99 <= div100(x99);
      end
      lwp_pkg::S_FETCH: begin
        cand   <= ram_rdata;
        cj     <= CW'(1);
        lt_cnt <= '0;
        le_cnt <= '0;
      end
      lwp_pkg::S_SCAN: begin
        if (ram_rdata < cand) begin
          lt_cnt <= lt_cnt + CW'(1);
        end
        if (ram_rdata <= cand) begin
          le_cnt <= le_cnt + CW'(1);
        end
        if (cj != rn) begin
          cj <= cj + CW'(1);
        end
      end
      lwp_pkg::S_EVAL: begin
        // The candidate owns every sorted position from lt_cnt up to le_cnt-1.
        if (lt_cnt <= k50 && k50 < le_cnt) r50 <= cand;
        if (lt_cnt <= k95 && k95 < le_cnt) r95 <= cand;
        if (lt_cnt <= k99 && k99 < le_cnt) r99 <= cand;
        ci <= ci + CW'(1);
      end
      lwp_pkg::S_DONE: begin
        rsp.accepted     <= 1'b0;
        rsp.sample_count <= lwp_pkg::COUNT_W'(rn);
        rsp.p50_value    <= r50;
        rsp.p95_value    <= r95;
        rsp.p99_value    <= r99;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/lwp_checker.sv =====
`include "latency_window_percentile_top_defines.svh"

module lwp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_accepted,
  input logic [lwp_pkg::COUNT_W-1:0]   rsp_count,
  input logic [lwp_pkg::SAMPLE_W-1:0]  rsp_p50,
  input logic [lwp_pkg::SAMPLE_W-1:0]  rsp_p95,
  input logic [lwp_pkg::SAMPLE_W-1:0]  rsp_p99
);

  `LWP_ASSERT_RST(a_reset_empty, rst, !rsp_valid)

  `LWP_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_accepted) && $stable(rsp_count) && $stable(rsp_p50))

  `LWP_ASSERT_NOW(a_observe_no_pct, rsp_valid && rsp_accepted,
    rsp_p50 == '0 && rsp_p95 == '0 && rsp_p99 == '0)

  `LWP_ASSERT_NOW(a_pct_order, rsp_valid, rsp_p50 <= rsp_p95 && rsp_p95 <= rsp_p99)

endmodule

bind latency_window_percentile_top lwp_checker u_lwp_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_accepted(rsp.accepted),
  .rsp_count   (rsp.sample_count),
  .rsp_p50     (rsp.p50_value),
  .rsp_p95     (rsp.p95_value),
  .rsp_p99     (rsp.p99_value)
);

// ===== sim/latency_window_percentile_top_tb.sv =====
module latency_window_percentile_top_tb;

  typedef struct packed {
    logic                         accepted;
    logic [lwp_pkg::COUNT_W-1:0]  sample_count;
    logic [lwp_pkg::SAMPLE_W-1:0] p50_value;
    logic [lwp_pkg::SAMPLE_W-1:0] p95_value;
    logic [lwp_pkg::SAMPLE_W-1:0] p99_value;
  } pct_rsp_t;

  typedef struct {
    logic                        cmd;
    logic [lwp_pkg::STAGE_W-1:0] stage;
    logic [lwp_pkg::LAT_W-1:0]   latency;
    bit                          typed;
    pct_rsp_t                    want;
  } dir_row_t;

  localparam int STAGES = 8;
  localparam int RING = 256;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lwp_pkg::CFG_W-1:0] cfg_wdata;

  lwp_req_if req_if ();
  lwp_rsp_if rsp_if ();

  latency_window_percentile_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // Shadow state of the per-stage sample rings.
  logic [lwp_pkg::SAMPLE_W-1:0] ring_mem [STAGES][RING];
  int unsigned                  win_cnt [STAGES];
  int unsigned                  win_head [STAGES];
  int unsigned                  window_size_reg;

  pct_rsp_t predicted_rsp_q [$];
  dir_row_t dir_tab [$];
  int       errors;
  int       n_observe;
  int       n_report;
  int       n_checked;
  int       max_report_n;
  bit       quiet;
  bit       hold_req;
  int       hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("latency_window_percentile_top regression: fail");
    $finish;
  end

  function automatic pct_rsp_t window_percentile_predict(
      input logic c,
      input logic [lwp_pkg::STAGE_W-1:0] s,
      input logic [lwp_pkg::LAT_W-1:0] l);
    pct_rsp_t r;
    int unsigned eff;
    int unsigned n;
    int unsigned drop;
    logic [lwp_pkg::SAMPLE_W-1:0] sorted [$];
    r = '0;
    if (c == lwp_pkg::CMD_OBSERVE) begin
      if (!l[lwp_pkg::LAT_W-1]) begin
        eff = (window_size_reg == 0) ? 1 : (window_size_reg > RING ? RING : window_size_reg);
        n = win_cnt[s];
        if (n >= eff) begin
          drop = (n / 4 == 0) ? 1 : n / 4;
          win_head[s] = (win_head[s] + drop) % RING;
          n = n - drop;
        end
        ring_mem[s][(win_head[s] + n) % RING] = l[lwp_pkg::SAMPLE_W-1:0];
        win_cnt[s] = n + 1;
        r.accepted = 1'b1;
      end
      r.sample_count = lwp_pkg::COUNT_W'(win_cnt[s]);
    end else begin
      n = win_cnt[s];
      for (int i = 0; i < n; i++)
        sorted.insert(sorted.size(), ring_mem[s][(win_head[s] + i) % RING]);
      sorted.sort();
      r.sample_count = lwp_pkg::COUNT_W'(n);
      if (n != 0) begin
        r.p50_value = sorted[(lwp_pkg::PCT_50 * (n - 1) + lwp_pkg::ROUND_HALF) / 100];
        r.p95_value = sorted[(lwp_pkg::PCT_95 * (n - 1) + lwp_pkg::ROUND_HALF) / 100];
        r.p99_value = sorted[(lwp_pkg::PCT_99 * (n - 1) + lwp_pkg::ROUND_HALF) / 100];
      end
      if (int'(n) > max_report_n) max_report_n = int'(n);
    end
    return r;
  endfunction

  function automatic logic [lwp_pkg::LAT_W-1:0] rand_latency();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 2) return {1'b1, 31'($urandom)};
    if (k < 5) return $urandom_range(0, 15);
    if (k < 7) return {1'b0, 31'($urandom)};
    return $urandom_range(0, 1000);
  endfunction

  task automatic add_row(input logic c, input logic [lwp_pkg::STAGE_W-1:0] s,
                         input logic [lwp_pkg::LAT_W-1:0] l, input bit typed,
                         input pct_rsp_t w);
    dir_row_t row;
    row.cmd = c;
    row.stage = s;
    row.latency = l;
    row.typed = typed;
    row.want = w;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  task automatic offer_item(input logic c, input logic [lwp_pkg::STAGE_W-1:0] s,
                            input logic [lwp_pkg::LAT_W-1:0] l, input bit typed,
                            input pct_rsp_t w);
    pct_rsp_t p;
    if (!quiet && $urandom_range(0, 99) < 14) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.cmd     <= c;
    req_if.stage   <= s;
    req_if.latency <= l;
    do @(posedge clk); while (!req_if.ready);
    p = window_percentile_predict(c, s, l);
    predicted_rsp_q.insert(predicted_rsp_q.size(), typed ? w : p);
    if (c == lwp_pkg::CMD_OBSERVE) n_observe++;
    else n_report++;
  endtask

  // Lets every outstanding transaction come back before the block is touched again.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window_size(input int unsigned v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lwp_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    window_size_reg = v;
  endtask

  task automatic random_phase(input int unsigned ws, input int items);
    logic c;
    write_window_size(ws);
    for (int i = 0; i < items; i++) begin
      c = ($urandom_range(0, 99) < 8) ? lwp_pkg::CMD_REPORT : lwp_pkg::CMD_OBSERVE;
      offer_item(c, lwp_pkg::STAGE_W'($urandom_range(0, 7)), rand_latency(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    pct_rsp_t w;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (predicted_rsp_q.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
      end else begin
        w = predicted_rsp_q.pop_front();
        n_checked++;
        if (rsp_if.accepted !== w.accepted) begin
          $error("accepted: expected %0d, got %0d", w.accepted, rsp_if.accepted);
          errors++;
        end
        if (rsp_if.sample_count !== w.sample_count) begin
          $error("sample_count: expected %0d, got %0d", w.sample_count, rsp_if.sample_count);
          errors++;
        end
        if (rsp_if.p50_value !== w.p50_value) begin
          $error("p50_value: expected %0d, got %0d", w.p50_value, rsp_if.p50_value);
          errors++;
        end
        if (rsp_if.p95_value !== w.p95_value) begin
          $error("p95_value: expected %0d, got %0d", w.p95_value, rsp_if.p95_value);
          errors++;
        end
        if (rsp_if.p99_value !== w.p99_value) begin
          $error("p99_value: expected %0d, got %0d", w.p99_value, rsp_if.p99_value);
          errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.cmd = lwp_pkg::CMD_OBSERVE;
    req_if.stage = '0;
    req_if.latency = '0;
    errors = 0;
    n_observe = 0;
    n_report = 0;
    n_checked = 0;
    max_report_n = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    window_size_reg = 32'(lwp_pkg::WINDOW_SIZE_RESET);
    for (int s = 0; s < STAGES; s++) begin
      win_cnt[s] = 0;
      win_head[s] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty windows, negative samples, extreme values and ties.
    add_row(lwp_pkg::CMD_REPORT,  3'd3, 32'h1234_5678, 1'b1, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd3, 32'h8000_0000, 1'b1, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd3, 32'hFFFF_FFFF, 1'b1, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd7, 32'h7FFF_FFFF, 1'b1,
            {1'b1, 9'd1, 31'd0, 31'd0, 31'd0});
    add_row(lwp_pkg::CMD_REPORT,  3'd7, 32'hFFFF_FFFF, 1'b1,
            {1'b0, 9'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF});
    add_row(lwp_pkg::CMD_OBSERVE, 3'd7, 32'h0000_0000, 1'b1,
            {1'b1, 9'd2, 31'd0, 31'd0, 31'd0});
    add_row(lwp_pkg::CMD_REPORT,  3'd7, 32'h0, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd0, 32'd5, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd0, 32'd1, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd0, 32'd9, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd0, 32'd1, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd0, 32'd3, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd0, 32'd7, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd0, 32'd2, 1'b0, '0);
    add_row(lwp_pkg::CMD_REPORT,  3'd0, 32'd0, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd5, 32'h5555_5555, 1'b0, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd5, 32'h2AAA_AAAA, 1'b0, '0);
    add_row(lwp_pkg::CMD_REPORT,  3'd5, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(lwp_pkg::CMD_REPORT,  3'd1, 32'h0, 1'b1, '0);
    add_row(lwp_pkg::CMD_OBSERVE, 3'd6, 32'hAAAA_AAAA, 1'b1, '0);
    add_row(lwp_pkg::CMD_REPORT,  3'd2, 32'h8000_0000, 1'b1, '0);
    foreach (dir_tab[i])
      offer_item(dir_tab[i].cmd, dir_tab[i].stage, dir_tab[i].latency,
                 dir_tab[i].typed, dir_tab[i].want);

    // Overfull setting, clamped to the ring size: fill one stage past eviction.
    // The receiver holds off for a while so the block backs up.
    write_window_size(300);
    hold_req = 1'b1;
    for (int i = 0; i < 260; i++)
      offer_item(lwp_pkg::CMD_OBSERVE, 3'd4, rand_latency(), 1'b0, '0);
    offer_item(lwp_pkg::CMD_REPORT, 3'd4, 32'd0, 1'b0, '0);
    for (int i = 0; i < 70; i++)
      offer_item(lwp_pkg::CMD_OBSERVE, 3'd4, rand_latency(), 1'b0, '0);
    offer_item(lwp_pkg::CMD_REPORT, 3'd4, 32'd0, 1'b0, '0);

    // Varied window settings; an observe into a full window evicts a quarter of it, at least one sample.
    random_phase(1, 160);
    random_phase(4, 160);
    quiet = 1'b1;
    random_phase(13, 160);
    quiet = 1'b0;
    random_phase(0, 160);
    random_phase(40, 160);
    random_phase(511, 160);
    random_phase(256, 60);

    req_if.valid <= 1'b0;
    guard = 0;
    while (predicted_rsp_q.size() != 0 && guard < 2_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    $display("Covered %0d observe and %0d report transactions, %0d results checked;",
             n_observe, n_report, n_checked);
    $display("window settings 0, 1, 4, 13, 40, 256, 300 and 511, largest report over %0d.",
             max_report_n);
    if (errors == 0 && predicted_rsp_q.size() == 0) begin
      $display("latency_window_percentile_top regression: pass");
    end else begin
      if (predicted_rsp_q.size() != 0)
        $error("%0d results never arrived", predicted_rsp_q.size());
      $display("latency_window_percentile_top regression: fail");
    end
    $finish;
  end

endmodule
